FILE: hw/rtl/expiring_failure_cache_macros.svh
// assertion macros for the failure cache
`ifndef EXPIRING_FAILURE_CACHE_MACROS_SVH
`define EXPIRING_FAILURE_CACHE_MACROS_SVH

// implication checked on every clock edge outside reset
`define EFC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define EFC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/efc_pkg.sv
// ----------------------------------------------------------------------------
// efc_pkg
// shared types and constants of the failure cache
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENTRY_W = 32 + 1 + 64 + 32;

    localparam logic [31:0] RETRY_DEFAULT = 32'd3000;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_CLRALL = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [63:0] version_stamp;
        logic        has_version;
        logic [31:0] now_tick;
        logic        item_present;
    } t_req;

    typedef struct packed {
        logic [31:0] key;
        logic        has_version;
        logic [63:0] version;
        logic [31:0] deadline;
    } t_entry;

    function automatic logic is_expired(input logic [31:0] dl, input logic [31:0] now);
        logic [31:0] d;
        d = dl - now;
        return (d == 32'd0) || d[31];
    endfunction

    function automatic logic is_earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

FILE: hw/rtl/efc_ram.sv
// ----------------------------------------------------------------------------
// efc_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module efc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hw/rtl/efc_front.sv
// ----------------------------------------------------------------------------
// efc_front
// input side: two-deep request queue between the port and the scan engine
// ----------------------------------------------------------------------------
module efc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  efc_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output efc_pkg::t_req  o_req
);
    efc_pkg::t_req r_q [2];
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[0];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push) begin
            if (pop) begin
                // one item held, so the new one lands at the head
                r_q[0] <= i_req;
            end else begin
                r_q[r_cnt[0]] <= i_req;
            end
        end
    end
endmodule

FILE: hw/rtl/efc_back.sv
// ----------------------------------------------------------------------------
// efc_back
// scan engine: walks the table up to a match (none for a clear-all), applying the operation
// ----------------------------------------------------------------------------
`include "expiring_failure_cache_macros.svh"
module efc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_retry,
    input  logic           i_valid,
    output logic           o_ready,
    input  efc_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_suppressed,
    output logic           o_evicted_live
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int IW = efc_pkg::IDX_W;
    localparam logic [IW-1:0] LAST = IW'(efc_pkg::ENTRIES - 1);

    logic [2:0]     r_state;
    efc_pkg::t_req  r_req;
    logic [IW-1:0]  r_idx;
    logic [efc_pkg::ENTRIES-1:0] r_vld;
    logic           r_have_free, r_have_old;
    logic [IW-1:0]  r_free, r_old;
    logic [31:0]    r_old_dl;
    logic [IW-1:0]  r_tgt;
    logic           r_sup, r_ev;
    logic           r_out_v;

    logic           we;
    logic [IW-1:0]  addr;
    efc_pkg::t_entry wdata, rdata;
    logic           hit, exp_e;
    logic [31:0]    dl;

    efc_ram #(.WIDTH(efc_pkg::ENTRY_W), .DEPTH(efc_pkg::ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    assign o_ready        = (r_state == S_IDLE) && !r_out_v;
    assign o_valid        = r_out_v;
    assign o_suppressed   = r_sup;
    assign o_evicted_live = r_ev;

    assign hit   = r_vld[r_idx] && (rdata.key == r_req.key);
    assign exp_e = efc_pkg::is_expired(rdata.deadline, r_req.now_tick);
    assign dl    = r_req.now_tick + i_retry;
    assign we    = (r_state == S_WRITE) && (r_req.op == efc_pkg::OP_RECORD);
    assign addr  = (r_state == S_WRITE) ? r_tgt : r_idx;

    always_comb begin
        wdata.key         = r_req.key;
        wdata.has_version = r_req.has_version;
        wdata.version     = r_req.has_version ? r_req.version_stamp : 64'd0;
        wdata.deadline    = (dl == 32'd0) ? 32'd1 : dl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req       <= i_req;
                        r_idx       <= '0;
                        r_have_free <= 1'b0;
                        r_have_old  <= 1'b0;
                        r_sup       <= 1'b0;
                        r_ev        <= 1'b0;
                        if (i_req.op == efc_pkg::OP_CLRALL) begin
                            r_vld   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_READ;
                    if (r_idx == LAST) begin
                        r_state <= S_DONE;
                    end
                    r_idx <= r_idx + 1'b1;
                    case (r_req.op)
                        efc_pkg::OP_QUERY: begin
                            if (hit) begin
                                r_state <= S_DONE;
                                if (exp_e || (!rdata.has_version && r_req.item_present)) begin
                                    r_vld[r_idx] <= 1'b0;
                                end else if (rdata.has_version == r_req.has_version) begin
                                    r_sup <= !r_req.has_version ||
                                             (rdata.version == r_req.version_stamp);
                                end
                            end
                        end
                        efc_pkg::OP_RECORD: begin
                            if (!r_vld[r_idx] || exp_e) begin
                                r_vld[r_idx] <= 1'b0;
                                if (!r_have_free) begin
                                    r_have_free <= 1'b1;
                                    r_free      <= r_idx;
                                end
                            end else if (rdata.key == r_req.key) begin
                                r_tgt   <= r_idx;
                                r_state <= S_WRITE;
                            end else if (!r_have_old ||
                                         efc_pkg::is_earlier(rdata.deadline, r_old_dl)) begin
                                r_have_old <= 1'b1;
                                r_old      <= r_idx;
                                r_old_dl   <= rdata.deadline;
                            end
                            if (r_idx == LAST && !(r_vld[r_idx] && !exp_e &&
                                                   rdata.key == r_req.key)) begin
                                r_state <= S_WRITE;
                                if (r_have_free || !r_vld[r_idx] || exp_e) begin
                                    r_tgt <= r_have_free ? r_free : r_idx;
                                end else if (!r_have_old ||
                                             efc_pkg::is_earlier(rdata.deadline, r_old_dl)) begin
                                    r_tgt <= r_idx;
                                    r_ev  <= 1'b1;
                                end else begin
                                    r_tgt <= r_old;
                                    r_ev  <= 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (hit) begin
                                r_vld[r_idx] <= 1'b0;
                                r_state      <= S_DONE;
                            end
                        end
                    endcase
                end
                S_WRITE: begin
                    r_vld[r_tgt] <= 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `EFC_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_out_v, !o_ready)
    `EFC_ASSERT_NEXT(a_done_gives_out, i_clk, i_rst_n, r_state == S_DONE, r_out_v)
    `EFC_ASSERT_IMP(a_sup_only_query, i_clk, i_rst_n, r_out_v && r_sup,
                    r_req.op == efc_pkg::OP_QUERY)
    `EFC_ASSERT_NEXT(a_write_sets_valid, i_clk, i_rst_n,
                     r_state == S_WRITE && r_req.op == efc_pkg::OP_RECORD, r_vld[$past(r_tgt)])
endmodule

FILE: hw/rtl/expiring_failure_cache.sv
// ----------------------------------------------------------------------------
// expiring_failure_cache
// table of failed items with wrap-aware retry deadlines
// ----------------------------------------------------------------------------
// Each query, record or key clear scans the table entry by entry through the
// single ram port, each entry passing a read state and an evaluate state; a
// match ends the scan early, and a clear-all skips the scan. A two-deep queue
// takes items while a scan runs.
module expiring_failure_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_key,
    input  logic [63:0] i_version_stamp,
    input  logic        i_has_version,
    input  logic [31:0] i_now_tick,
    input  logic        i_item_present,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_suppressed,
    output logic        o_evicted_live
);
    logic [31:0]   r_retry;
    efc_pkg::t_req req_in, req_q;
    logic          q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry <= efc_pkg::RETRY_DEFAULT;
        end else if (i_cfg_we) begin
            r_retry <= i_cfg_wdata;
        end
    end

    always_comb begin
        req_in.op            = i_op;
        req_in.key           = i_key;
        req_in.version_stamp = i_version_stamp;
        req_in.has_version   = i_has_version;
        req_in.now_tick      = i_now_tick;
        req_in.item_present  = i_item_present;
    end

    efc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (req_in),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_req   (req_q)
    );

    efc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_retry        (r_retry),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_req          (req_q),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_suppressed   (o_suppressed),
        .o_evicted_live (o_evicted_live)
    );
endmodule

FILE: test/efc_checker.sv
// ----------------------------------------------------------------------------
// efc_checker
// watches both channels of the failure cache, predicts each result and
// compares it with what comes out
// ----------------------------------------------------------------------------
// A table of the same shape as the block's is kept here. Every accepted
// request updates it and queues the expected flags. Every accepted result
// is compared with the oldest queued flags. Register writes and reset are
// followed as the block sees them.
module efc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_key,
    input  logic [63:0] i_version_stamp,
    input  logic        i_has_version,
    input  logic [31:0] i_now_tick,
    input  logic        i_item_present,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_suppressed,
    input  logic        i_evicted_live,
    output int          o_pending,
    output int          o_fails
);

    typedef struct packed {
        logic suppressed;
        logic evicted_live;
    } t_flags;

    logic        live_bit   [efc_pkg::ENTRIES];
    logic [31:0] tag_key    [efc_pkg::ENTRIES];
    logic        tag_hasver [efc_pkg::ENTRIES];
    logic [63:0] tag_ver    [efc_pkg::ENTRIES];
    logic [31:0] tag_due    [efc_pkg::ENTRIES];
    logic [31:0] retry_ticks;
    t_flags      flags_due [$];

    function automatic logic lapsed(input logic [31:0] due, input logic [31:0] now);
        logic [31:0] d;
        d = due - now;
        return (d == 32'd0) || d[31];
    endfunction

    function automatic logic sooner(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic void forget(input int i);
        live_bit[i] = 1'b0;
    endfunction

    function automatic t_flags cache_step(input efc_pkg::t_req r);
        t_flags f;
        int     slot;
        int     free_slot;
        int     oldest;
        logic   hit;
        logic [31:0] due;
        f = '0;
        slot = -1;
        free_slot = -1;
        oldest = -1;
        hit = 1'b0;
        case (r.op)
            efc_pkg::OP_QUERY: begin
                for (int i = 0; i < efc_pkg::ENTRIES; i++) begin
                    if (slot < 0 && live_bit[i] && tag_key[i] == r.key) slot = i;
                end
                if (slot >= 0) begin
                    if (lapsed(tag_due[slot], r.now_tick)) begin
                        forget(slot);
                    end else if (!tag_hasver[slot] && r.item_present) begin
                        forget(slot);
                    end else if (tag_hasver[slot] != r.has_version) begin
                        f.suppressed = 1'b0;
                    end else if (!r.has_version) begin
                        f.suppressed = 1'b1;
                    end else begin
                        f.suppressed = (tag_ver[slot] == r.version_stamp);
                    end
                end
            end
            efc_pkg::OP_RECORD: begin
                for (int i = 0; i < efc_pkg::ENTRIES && !hit; i++) begin
                    if (!live_bit[i] || lapsed(tag_due[i], r.now_tick)) begin
                        forget(i);
                        if (free_slot < 0) free_slot = i;
                    end else if (tag_key[i] == r.key) begin
                        slot = i;
                        hit = 1'b1;
                    end else if (oldest < 0 || sooner(tag_due[i], tag_due[oldest])) begin
                        oldest = i;
                    end
                end
                if (!hit) begin
                    if (free_slot >= 0) begin
                        slot = free_slot;
                    end else begin
                        slot = oldest;
                        f.evicted_live = 1'b1;
                    end
                end
                due = r.now_tick + retry_ticks;
                if (due == 32'd0) due = 32'd1;
                live_bit[slot] = 1'b1;
                tag_key[slot] = r.key;
                tag_hasver[slot] = r.has_version;
                tag_ver[slot] = r.has_version ? r.version_stamp : 64'd0;
                tag_due[slot] = due;
            end
            efc_pkg::OP_CLEAR: begin
                for (int i = 0; i < efc_pkg::ENTRIES; i++) begin
                    if (slot < 0 && live_bit[i] && tag_key[i] == r.key) slot = i;
                end
                if (slot >= 0) forget(slot);
            end
            default: begin
                for (int i = 0; i < efc_pkg::ENTRIES; i++) forget(i);
            end
        endcase
        return f;
    endfunction

    always @(posedge i_clk) begin
        efc_pkg::t_req r;
        t_flags        want;
        if (!i_rst_n) begin
            for (int i = 0; i < efc_pkg::ENTRIES; i++) live_bit[i] = 1'b0;
            retry_ticks = efc_pkg::RETRY_DEFAULT;
            flags_due.delete();
            o_fails <= 0;
        end else begin
            if (i_cfg_we) retry_ticks = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (flags_due.size() == 0) begin
                    if (o_fails < 10) $display("result with nothing expected: sup=%0b ev=%0b",
                                               i_suppressed, i_evicted_live);
                    o_fails <= o_fails + 1;
                end else begin
                    want = flags_due.pop_front();
                    if (want.suppressed !== i_suppressed
                            || want.evicted_live !== i_evicted_live) begin
                        if (o_fails < 10) $display("mismatch: expected sup=%0b ev=%0b got sup=%0b ev=%0b",
                                                   want.suppressed, want.evicted_live,
                                                   i_suppressed, i_evicted_live);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                r = '{op: i_op, key: i_key, version_stamp: i_version_stamp,
                      has_version: i_has_version, now_tick: i_now_tick,
                      item_present: i_item_present};
                flags_due.push_back(cache_step(r));
            end
        end
        o_pending <= flags_due.size();
    end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the expiring failure cache
// ----------------------------------------------------------------------------
// A directed sequence covers version checks, presence clears, key and full
// clears and the wrapped zero deadline. Random phases then run under several
// retry intervals, among them a single tick and the largest, and one phase fills
// the table with distinct keys to force evictions. The checker beside the
// block predicts and compares; this module only drives and decides.
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [31:0] i_key;
    logic [63:0] i_version_stamp;
    logic        i_has_version;
    logic [31:0] i_now_tick;
    logic        i_item_present;
    logic        o_valid;
    logic        i_ready = 1'b1;
    logic        o_suppressed;
    logic        o_evicted_live;
    int          pending;
    int          fails;
    logic        idling;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_now;
    logic [31:0] key_pool [16];
    int          fresh_key;

    expiring_failure_cache dut (.*);

    efc_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_valid, .i_ready_in(o_ready), .i_op, .i_key, .i_version_stamp,
        .i_has_version, .i_now_tick, .i_item_present,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_suppressed(o_suppressed), .i_evicted_live(o_evicted_live),
        .o_pending(pending), .o_fails(fails)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (idling && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 10);
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= (stall_left == 1);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] key,
                             input logic [63:0] ver, input logic hv,
                             input logic [31:0] now, input logic pres);
        logic ok;
        int   gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_key <= key;
        i_version_stamp <= ver;
        i_has_version <= hv;
        i_now_tick <= now;
        i_item_present <= pres;
        ok = 1'b0;
        while (!ok) begin
            @(negedge i_clk);
            ok = o_ready;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_retry(input logic [31:0] ticks);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_item(input int spread);
        logic [1:0]  op;
        logic [31:0] key;
        logic [63:0] ver;
        int          pick;
        pick = $urandom_range(0, 99);
        op = (pick < 42) ? efc_pkg::OP_QUERY : (pick < 84) ? efc_pkg::OP_RECORD :
             (pick < 97) ? efc_pkg::OP_CLEAR : efc_pkg::OP_CLRALL;
        key = ($urandom_range(0, 19) == 0) ? $urandom() : key_pool[$urandom_range(0, 15)];
        case ($urandom_range(0, 3))
            0: ver = 64'd0;
            1: ver = '1;
            2: ver = {32'd0, key};
            default: ver = {$urandom(), $urandom()};
        endcase
        if ($urandom_range(0, 49) == 0) clock_now = $urandom();
        else clock_now = clock_now + $urandom_range(0, spread);
        send_item(op, key, ver, 1'($urandom_range(0, 1)), clock_now,
                  1'($urandom_range(0, 1)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_op = efc_pkg::OP_QUERY;
        i_key = '0;
        i_version_stamp = '0;
        i_has_version = 1'b0;
        i_now_tick = '0;
        i_item_present = 1'b0;
        idling = 1'b0;
        fresh_key = 0;
        clock_now = 32'hFFFF_F000;
        key_pool[0] = 32'd0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++) key_pool[i] = $urandom();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the default interval
        send_item(efc_pkg::OP_RECORD, 32'd0, '1, 1'b0, 32'd100, 1'b1);
        send_item(efc_pkg::OP_QUERY, 32'd0, '0, 1'b0, 32'd200, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'd0, '0, 1'b0, 32'd300, 1'b1);
        send_item(efc_pkg::OP_QUERY, 32'd0, '0, 1'b0, 32'd300, 1'b0);
        send_item(efc_pkg::OP_RECORD, 32'hFFFF_FFFF, '1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'hFFFF_FFFF, '1, 1'b1, 32'd10, 1'b1);
        send_item(efc_pkg::OP_QUERY, 32'hFFFF_FFFF, '0, 1'b1, 32'd10, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'hFFFF_FFFF, '1, 1'b0, 32'd10, 1'b0);
        send_item(efc_pkg::OP_RECORD, 32'hFFFF_FFFF, 64'h5555_AAAA_0F0F_F0F0, 1'b1,
                  32'd20, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'hFFFF_FFFF, 64'h5555_AAAA_0F0F_F0F0, 1'b1,
                  32'd30, 1'b0);
        send_item(efc_pkg::OP_CLEAR, 32'hFFFF_FFFF, '0, 1'b0, 32'd40, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'hFFFF_FFFF, 64'h5555_AAAA_0F0F_F0F0, 1'b1,
                  32'd50, 1'b0);
        send_item(efc_pkg::OP_CLEAR, 32'h1234_5678, '0, 1'b0, 32'd60, 1'b0);
        // wrapped deadline of zero is stored as one
        send_item(efc_pkg::OP_RECORD, 32'd5, '0, 1'b0, 32'hFFFF_F448, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'd5, '0, 1'b0, 32'd0, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'd5, '0, 1'b0, 32'd1, 1'b0);
        send_item(efc_pkg::OP_RECORD, 32'd6, '0, 1'b0, 32'd1000, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'd6, '0, 1'b0, 32'd3999, 1'b0);
        send_item(efc_pkg::OP_QUERY, 32'd6, '0, 1'b0, 32'd4000, 1'b0);
        send_item(efc_pkg::OP_RECORD, 32'd7, '1, 1'b1, 32'd4000, 1'b0);
        send_item(efc_pkg::OP_CLRALL, 32'd7, '1, 1'b1, 32'd4000, 1'b1);
        send_item(efc_pkg::OP_QUERY, 32'd7, '1, 1'b1, 32'd4001, 1'b0);

        idling = 1'b1;
        set_retry(32'd1);
        repeat (300) random_item(2);
        set_retry(32'hFFFF_FFFF);
        repeat (200) random_item(100);
        set_retry(32'h7FFF_FFFF);
        repeat (50) random_item(1000);

        // fill past capacity with distinct keys to force evictions
        set_retry(32'h1000_0000);
        send_item(efc_pkg::OP_CLRALL, 32'd0, '0, 1'b0, clock_now, 1'b0);
        for (int n = 0; n < 400; n++) begin
            if ($urandom_range(0, 3) != 0) begin
                fresh_key++;
                if ($urandom_range(0, 1) == 0) clock_now = clock_now + $urandom_range(0, 50);
                send_item(efc_pkg::OP_RECORD, 32'hA000_0000 + fresh_key,
                          {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
                          clock_now, 1'b0);
            end else begin
                send_item(efc_pkg::OP_QUERY, 32'hA000_0000 + $urandom_range(0, fresh_key),
                          '0, 1'b0, clock_now, 1'b0);
            end
        end

        set_retry(efc_pkg::RETRY_DEFAULT);
        repeat (800) random_item(200);
        drain();
        idling = 1'b0;
        repeat (120) random_item(200);

        drain();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
